/* src/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Request modes, control bytes, register indexes, controller states and
// the command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

   // request modes
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   // control register indexes
   localparam logic CSR_CHAR_ATTRIBUTE = 1'b0;
   localparam logic CSR_BLANK_CELL     = 1'b1;

   localparam logic [7:0]  ATTR_RESET  = 8'h07;
   localparam logic [15:0] BLANK_RESET = 16'h0720;

   // control bytes
   localparam logic [7:0] CHR_NUL = 8'h00;
   localparam logic [7:0] CHR_ENQ = 8'h05;
   localparam logic [7:0] CHR_BEL = 8'h07;
   localparam logic [7:0] CHR_BS  = 8'h08;
   localparam logic [7:0] CHR_HT  = 8'h09;
   localparam logic [7:0] CHR_LF  = 8'h0A;
   localparam logic [7:0] CHR_VT  = 8'h0B;
   localparam logic [7:0] CHR_FF  = 8'h0C;
   localparam logic [7:0] CHR_CR  = 8'h0D;
   localparam logic [7:0] CHR_DEL = 8'h7F;

   typedef enum logic [2:0] {
      CLS_IGNORE,
      CLS_BEL,
      CLS_BS,
      CLS_LF,
      CLS_FF,
      CLS_CR,
      CLS_DEL,
      CLS_PRINT
   } class_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CLEAR,
      ST_LF,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_REBASE,
      ST_BLANK_SETUP,
      ST_BLANK,
      ST_SCROLL,
      ST_CR,
      ST_PUT,
      ST_FINISH
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_RD_REQ,
      OP_CLR_INIT,
      OP_CLEAR,
      OP_BS,
      OP_CR,
      OP_ERASE,
      OP_LF_DOWN,
      OP_COPY_INIT,
      OP_COPY_RD,
      OP_COPY_WR,
      OP_REBASE,
      OP_BLANK_INIT,
      OP_BLANK,
      OP_SCROLL,
      OP_PUT,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      class_type  cls;
      logic       col_zero;
      logic       col_wrap;
      logic       row_last;
      logic       need_rebase;
      logic       clear_last;
      logic       copy_last;
      logic       blank_last;
   } status_type;

   // sort a byte into its handling class
   function automatic class_type char_class(input logic [7:0] ch);
      class_type cls;
      case (ch)
         CHR_NUL, CHR_ENQ, CHR_HT, CHR_VT: cls = CLS_IGNORE;
         CHR_BEL: cls = CLS_BEL;
         CHR_BS:  cls = CLS_BS;
         CHR_LF:  cls = CLS_LF;
         CHR_FF:  cls = CLS_FF;
         CHR_CR:  cls = CLS_CR;
         CHR_DEL: cls = CLS_DEL;
         default: cls = CLS_PRINT;
      endcase
      return cls;
   endfunction

endpackage

/* src/tcw_ctrl.sv */
// ----------------------------------------------------------------------------
// tcw_ctrl: sequencer of the text console writer
// Walks one transaction through decode, line feed, scroll, screen copy,
// clear sweep and result hand-off, issuing at most one datapath command a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  tcw_pkg::status_type status,
   output tcw_pkg::cmd_type    cmd
);

   tcw_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_busy;

   // state register and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_busy  = rsp_valid_ff & rsp_stall;
   assign req_stall = (state_ff != tcw_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and command
   always_comb begin
      state_in = state_ff;
      cmd.op   = tcw_pkg::OP_NONE;
      case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = tcw_pkg::OP_LOAD;
               state_in = tcw_pkg::ST_DECODE;
            end
         end
         tcw_pkg::ST_DECODE: begin
            case (status.mode)
               tcw_pkg::MODE_READ: begin
                  cmd.op   = tcw_pkg::OP_RD_REQ;
                  state_in = tcw_pkg::ST_FINISH;
               end
               tcw_pkg::MODE_CLEAR: begin
                  cmd.op   = tcw_pkg::OP_CLR_INIT;
                  state_in = tcw_pkg::ST_CLEAR;
               end
               tcw_pkg::MODE_WRITE: begin
                  state_in = tcw_pkg::ST_FINISH;
                  case (status.cls)
                     tcw_pkg::CLS_BS: begin
                        if (!status.col_zero) cmd.op = tcw_pkg::OP_BS;
                     end
                     tcw_pkg::CLS_CR:  cmd.op = tcw_pkg::OP_CR;
                     tcw_pkg::CLS_DEL: cmd.op = tcw_pkg::OP_ERASE;
                     tcw_pkg::CLS_LF, tcw_pkg::CLS_FF: state_in = tcw_pkg::ST_LF;
                     tcw_pkg::CLS_PRINT: begin
                        state_in = status.col_wrap ? tcw_pkg::ST_LF : tcw_pkg::ST_PUT;
                     end
                     default: ;
                  endcase
               end
               default: state_in = tcw_pkg::ST_FINISH;
            endcase
         end
         tcw_pkg::ST_CLEAR: begin
            cmd.op = tcw_pkg::OP_CLEAR;
            if (status.clear_last) state_in = tcw_pkg::ST_FINISH;
         end
         // line feed: step down, or scroll with an optional rebase first
         tcw_pkg::ST_LF: begin
            if (!status.row_last) begin
               cmd.op   = tcw_pkg::OP_LF_DOWN;
               state_in = (status.cls == tcw_pkg::CLS_FF) ? tcw_pkg::ST_FINISH
                                                         : tcw_pkg::ST_CR;
            end else if (status.need_rebase) begin
               cmd.op   = tcw_pkg::OP_COPY_INIT;
               state_in = tcw_pkg::ST_COPY_RD;
            end else begin
               state_in = tcw_pkg::ST_BLANK_SETUP;
            end
         end
         tcw_pkg::ST_COPY_RD: begin
            cmd.op   = tcw_pkg::OP_COPY_RD;
            state_in = tcw_pkg::ST_COPY_WR;
         end
         tcw_pkg::ST_COPY_WR: begin
            cmd.op   = tcw_pkg::OP_COPY_WR;
            state_in = status.copy_last ? tcw_pkg::ST_REBASE : tcw_pkg::ST_COPY_RD;
         end
         tcw_pkg::ST_REBASE: begin
            cmd.op   = tcw_pkg::OP_REBASE;
            state_in = tcw_pkg::ST_BLANK_SETUP;
         end
         tcw_pkg::ST_BLANK_SETUP: begin
            cmd.op   = tcw_pkg::OP_BLANK_INIT;
            state_in = tcw_pkg::ST_BLANK;
         end
         tcw_pkg::ST_BLANK: begin
            cmd.op = tcw_pkg::OP_BLANK;
            if (status.blank_last) state_in = tcw_pkg::ST_SCROLL;
         end
         tcw_pkg::ST_SCROLL: begin
            cmd.op   = tcw_pkg::OP_SCROLL;
            state_in = (status.cls == tcw_pkg::CLS_FF) ? tcw_pkg::ST_FINISH
                                                      : tcw_pkg::ST_CR;
         end
         tcw_pkg::ST_CR: begin
            cmd.op   = tcw_pkg::OP_CR;
            state_in = (status.cls == tcw_pkg::CLS_PRINT) ? tcw_pkg::ST_PUT
                                                         : tcw_pkg::ST_FINISH;
         end
         tcw_pkg::ST_PUT: begin
            cmd.op   = tcw_pkg::OP_PUT;
            state_in = tcw_pkg::ST_FINISH;
         end
         // hand the result over once the output register is free
         tcw_pkg::ST_FINISH: begin
            if (!out_busy) begin
               cmd.op   = tcw_pkg::OP_FINISH;
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         default: state_in = tcw_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid_in = (cmd.op == tcw_pkg::OP_FINISH) | out_busy;

endmodule

/* src/tcw_datapath.sv */
// ----------------------------------------------------------------------------
// tcw_datapath: cell store, position registers and result register
// Executes one controller command a cycle: cell writes, cursor moves,
// screen copy and row blanking steps, clear sweep and result capture.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_datapath #(
   parameter int COLS      = 80,
   parameter int ROWS      = 25,
   parameter int MEM_CELLS = 8192
) (
   input  logic                clock,
   input  logic                reset,
   input  tcw_pkg::cmd_type    cmd,
   output tcw_pkg::status_type status,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [15:0]         csr_write_data,
   input  logic [1:0]          req_mode,
   input  logic [7:0]          req_char_code,
   input  logic                req_last_of_write,
   input  logic [12:0]         req_read_cell,
   output logic [12:0]         rsp_cursor_register,
   output logic [12:0]         rsp_screen_start,
   output logic [6:0]          rsp_column,
   output logic [4:0]          rsp_line,
   output logic                rsp_beep,
   output logic [15:0]         rsp_cell_data
);

   localparam int AW           = $clog2(MEM_CELLS);
   localparam int XW           = AW + 1;
   localparam int CLW          = $clog2(COLS + 1);
   localparam int RWD          = $clog2(ROWS);
   localparam int SCREEN_CELLS = COLS * ROWS;
   localparam int SCREEN_MOD   = SCREEN_CELLS % MEM_CELLS;
   localparam int CNT_MAX      = (MEM_CELLS > SCREEN_CELLS) ? MEM_CELLS : SCREEN_CELLS;
   localparam int CW           = $clog2(CNT_MAX + 1);
   localparam int SUMW         = $clog2(MEM_CELLS + SCREEN_CELLS + COLS + 1);

   // modular cell index arithmetic, both operands below MEM_CELLS
   function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a, input logic [AW-1:0] b);
      logic [XW-1:0] sum;
      sum = XW'(a) + XW'(b);
      if (sum >= XW'(MEM_CELLS)) sum = sum - XW'(MEM_CELLS);
      return sum[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] sub_mod(input logic [AW-1:0] a, input logic [AW-1:0] b);
      logic [XW-1:0] diff;
      if (a >= b) diff = XW'(a) - XW'(b);
      else        diff = XW'(a) + XW'(MEM_CELLS) - XW'(b);
      return diff[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] inc_mod(input logic [AW-1:0] a);
      return (a == AW'(MEM_CELLS - 1)) ? '0 : a + 1'b1;
   endfunction

   logic [15:0]    mem [MEM_CELLS];
   logic           mem_we, mem_re;
   logic [AW-1:0]  mem_waddr, mem_raddr;
   logic [15:0]    mem_wdata;
   logic [15:0]    rdata_ff;

   logic [AW-1:0]  start_ff, start_in;
   logic [AW-1:0]  cursor_ff, cursor_in;
   logic [AW-1:0]  shown_ff, shown_in;
   logic [CLW-1:0] col_ff, col_in;
   logic [RWD-1:0] row_ff, row_in;
   logic [7:0]     attr_ff, attr_in;
   logic [15:0]    blank_ff, blank_in;

   logic [1:0]     mode_ff, mode_in;
   logic [7:0]     char_ff, char_in;
   logic           last_ff, last_in;
   logic [12:0]    rd_ff, rd_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [AW-1:0]  src_ff, src_in;
   logic [AW-1:0]  dst_ff, dst_in;

   logic [12:0]    out_cursor_ff, out_cursor_in;
   logic [12:0]    out_start_ff, out_start_in;
   logic [6:0]     out_col_ff, out_col_in;
   logic [4:0]     out_row_ff, out_row_in;
   logic           out_beep_ff, out_beep_in;
   logic [15:0]    out_data_ff, out_data_in;

   logic [XW-1:0]  rd_ext, rd_wrap;
   logic [AW-1:0]  rd_addr, cursor_dec;
   tcw_pkg::class_type cls;

   // read index folded into the store (below twice its depth)
   assign rd_ext     = XW'(rd_ff);
   assign rd_wrap    = (rd_ext >= XW'(MEM_CELLS)) ? rd_ext - XW'(MEM_CELLS) : rd_ext;
   assign rd_addr    = rd_wrap[AW-1:0];
   assign cursor_dec = (cursor_ff == '0) ? AW'(MEM_CELLS - 1) : cursor_ff - 1'b1;
   assign cls        = tcw_pkg::char_class(char_ff);

   // status toward the controller
   always_comb begin
      status.mode        = mode_ff;
      status.cls         = cls;
      status.col_zero    = (col_ff == '0);
      status.col_wrap    = (col_ff >= CLW'(COLS));
      status.row_last    = (row_ff >= RWD'(ROWS - 1));
      status.need_rebase = (SUMW'(start_ff) + SUMW'(SCREEN_CELLS + COLS)) > SUMW'(MEM_CELLS);
      status.clear_last  = (cnt_ff == CW'(MEM_CELLS - 1));
      status.copy_last   = (cnt_ff == CW'(SCREEN_CELLS - 1));
      status.blank_last  = (cnt_ff == CW'(COLS - 1));
   end

   // command execution
   always_comb begin
      start_in      = start_ff;
      cursor_in     = cursor_ff;
      shown_in      = shown_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      attr_in       = attr_ff;
      blank_in      = blank_ff;
      mode_in       = mode_ff;
      char_in       = char_ff;
      last_in       = last_ff;
      rd_in         = rd_ff;
      cnt_in        = cnt_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      out_cursor_in = out_cursor_ff;
      out_start_in  = out_start_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      out_beep_in   = out_beep_ff;
      out_data_in   = out_data_ff;
      mem_we        = 1'b0;
      mem_waddr     = cursor_ff;
      mem_wdata     = blank_ff;
      mem_re        = 1'b0;
      mem_raddr     = rd_addr;

      if (csr_write_enable) begin
         case (csr_index)
            tcw_pkg::CSR_CHAR_ATTRIBUTE: attr_in  = csr_write_data[7:0];
            tcw_pkg::CSR_BLANK_CELL:     blank_in = csr_write_data;
            default: ;
         endcase
      end

      case (cmd.op)
         tcw_pkg::OP_LOAD: begin
            mode_in = req_mode;
            char_in = req_char_code;
            last_in = req_last_of_write;
            rd_in   = req_read_cell;
         end
         tcw_pkg::OP_RD_REQ: mem_re = 1'b1;
         tcw_pkg::OP_CLR_INIT: begin
            start_in  = '0;
            cursor_in = '0;
            shown_in  = '0;
            col_in    = '0;
            row_in    = '0;
            cnt_in    = '0;
            dst_in    = '0;
         end
         tcw_pkg::OP_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = dst_ff;
            dst_in    = inc_mod(dst_ff);
            cnt_in    = cnt_ff + 1'b1;
         end
         // back space: step back and erase that cell
         tcw_pkg::OP_BS: begin
            mem_we    = 1'b1;
            mem_waddr = cursor_dec;
            cursor_in = cursor_dec;
            col_in    = col_ff - 1'b1;
         end
         tcw_pkg::OP_CR: begin
            cursor_in = sub_mod(cursor_ff, AW'(col_ff));
            col_in    = '0;
         end
         tcw_pkg::OP_ERASE: mem_we = 1'b1;
         tcw_pkg::OP_LF_DOWN: begin
            row_in    = row_ff + 1'b1;
            cursor_in = add_mod(cursor_ff, AW'(COLS));
         end
         // screen copy down to cell 0, one read and one write per cell
         tcw_pkg::OP_COPY_INIT: begin
            cnt_in = '0;
            src_in = start_ff;
            dst_in = '0;
         end
         tcw_pkg::OP_COPY_RD: begin
            mem_re    = 1'b1;
            mem_raddr = src_ff;
         end
         tcw_pkg::OP_COPY_WR: begin
            mem_we    = 1'b1;
            mem_waddr = dst_ff;
            mem_wdata = rdata_ff;
            src_in    = inc_mod(src_ff);
            dst_in    = inc_mod(dst_ff);
            cnt_in    = cnt_ff + 1'b1;
         end
         tcw_pkg::OP_REBASE: begin
            cursor_in = sub_mod(cursor_ff, start_ff);
            start_in  = '0;
         end
         // blank the row that scrolls in
         tcw_pkg::OP_BLANK_INIT: begin
            dst_in = add_mod(start_ff, AW'(SCREEN_MOD));
            cnt_in = '0;
         end
         tcw_pkg::OP_BLANK: begin
            mem_we    = 1'b1;
            mem_waddr = dst_ff;
            dst_in    = inc_mod(dst_ff);
            cnt_in    = cnt_ff + 1'b1;
         end
         tcw_pkg::OP_SCROLL: begin
            start_in  = add_mod(start_ff, AW'(COLS));
            cursor_in = add_mod(cursor_ff, AW'(COLS));
         end
         tcw_pkg::OP_PUT: begin
            mem_we    = 1'b1;
            mem_wdata = {attr_ff, char_ff};
            cursor_in = inc_mod(cursor_ff);
            col_in    = col_ff + 1'b1;
         end
         // result capture, cursor register follows on the last byte
         tcw_pkg::OP_FINISH: begin
            if (mode_ff == tcw_pkg::MODE_WRITE && last_ff) shown_in = cursor_ff;
            out_cursor_in = 13'(shown_in);
            out_start_in  = 13'(start_ff);
            out_col_in    = 7'(col_ff);
            out_row_in    = 5'(row_ff);
            out_beep_in   = (mode_ff == tcw_pkg::MODE_WRITE) && (cls == tcw_pkg::CLS_BEL);
            out_data_in   = (mode_ff == tcw_pkg::MODE_READ) ? rdata_ff : 16'h0000;
         end
         default: ;
      endcase
   end

   // position and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         cursor_ff <= '0;
         shown_ff  <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         attr_ff   <= tcw_pkg::ATTR_RESET;
         blank_ff  <= tcw_pkg::BLANK_RESET;
      end else begin
         start_ff  <= start_in;
         cursor_ff <= cursor_in;
         shown_ff  <= shown_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         attr_ff   <= attr_in;
         blank_ff  <= blank_in;
      end
   end

   // transaction fields, sweep counters, result register
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      char_ff       <= char_in;
      last_ff       <= last_in;
      rd_ff         <= rd_in;
      cnt_ff        <= cnt_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      out_cursor_ff <= out_cursor_in;
      out_start_ff  <= out_start_in;
      out_col_ff    <= out_col_in;
      out_row_ff    <= out_row_in;
      out_beep_ff   <= out_beep_in;
      out_data_ff   <= out_data_in;
   end

   // cell store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rdata_ff <= mem[mem_raddr];
   end

   assign rsp_cursor_register = out_cursor_ff;
   assign rsp_screen_start    = out_start_ff;
   assign rsp_column          = out_col_ff;
   assign rsp_line            = out_row_ff;
   assign rsp_beep            = out_beep_ff;
   assign rsp_cell_data       = out_data_ff;

endmodule

/* src/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console cell writer
// Printable byte: accept, decode, cell write, result; other bytes, reads and
// the unused mode: accept, decode, result. A line feed adds a row step or a
// scroll that blanks the incoming row; a screen rebase first copies the screen
// to cell 0 (one store port read and write per cell); clear sweeps the store.
// A stalled result holds the next transaction in its last cycle until taken.
// Reset clears positions, attribute, blank cell and result valid; the store stays undefined until a clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_writer #(
   parameter int COLS      = 80,
   parameter int ROWS      = 25,
   parameter int MEM_CELLS = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_of_write,
   input  logic [12:0] req_read_cell,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [12:0] rsp_cursor_register,
   output logic [12:0] rsp_screen_start,
   output logic [6:0]  rsp_column,
   output logic [4:0]  rsp_line,
   output logic        rsp_beep,
   output logic [15:0] rsp_cell_data
);

   tcw_pkg::cmd_type    cmd;
   tcw_pkg::status_type status;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .COLS      (COLS),
      .ROWS      (ROWS),
      .MEM_CELLS (MEM_CELLS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_mode            (req_mode),
      .req_char_code       (req_char_code),
      .req_last_of_write   (req_last_of_write),
      .req_read_cell       (req_read_cell),
      .rsp_cursor_register (rsp_cursor_register),
      .rsp_screen_start    (rsp_screen_start),
      .rsp_column          (rsp_column),
      .rsp_line            (rsp_line),
      .rsp_beep            (rsp_beep),
      .rsp_cell_data       (rsp_cell_data)
   );

   // an accepted transaction keeps the input side busy next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while previous transaction in flight");

   // the result register is only loaded when it is free
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.op == tcw_pkg::OP_FINISH |-> !(rsp_valid && rsp_stall))
      else $error("result overwritten while stalled");

   // no result pending right after reset
   a_reset_clears_result: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

/* bench/text_console_writer_checker.sv */
// ----------------------------------------------------------------------------
// text_console_writer_checker: scoreboard for the text console writer
// Watches the register port and both channels. Keeps its own copy of the
// cell store, screen start, cursor and attribute state, computes the
// expected status for every accepted request and compares each accepted
// response, field by field, against the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_writer_checker #(
   parameter int COLS      = 80,
   parameter int ROWS      = 25,
   parameter int MEM_CELLS = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_of_write,
   input  logic [12:0] req_read_cell,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [12:0] rsp_cursor_register,
   input  logic [12:0] rsp_screen_start,
   input  logic [6:0]  rsp_column,
   input  logic [4:0]  rsp_line,
   input  logic        rsp_beep,
   input  logic [15:0] rsp_cell_data,
   output int          fail_count,
   output int          pending_count
);

   localparam int unsigned SCREEN_CELLS = COLS * ROWS;

   typedef struct packed {
      logic [12:0] cursor_register;
      logic [12:0] screen_start;
      logic [6:0]  column;
      logic [4:0]  line;
      logic        beep;
      logic [15:0] cell_data;
   } console_status_type;

   console_status_type expected_status[$];

   // console state as the block should hold it
   logic [15:0] cell_mem [MEM_CELLS];
   int unsigned view_start;
   int unsigned cursor_pos;
   int unsigned cursor_reg;
   int unsigned col_pos;
   int unsigned row_pos;
   logic [7:0]  attr_byte;
   logic [15:0] blank_word;
   int          rsp_seen;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      rsp_seen      = 0;
   end

   function automatic int unsigned step_back(input int unsigned pos, input int unsigned n);
      return (pos % MEM_CELLS + MEM_CELLS - n % MEM_CELLS) % MEM_CELLS;
   endfunction

   task automatic write_cell(input int unsigned idx, input logic [15:0] word);
      cell_mem[idx % MEM_CELLS] = word;
   endtask

   // rebase the screen to cell 0 if needed, blank the new row, advance
   task automatic scroll_screen();
      int unsigned i;
      if (view_start + SCREEN_CELLS + COLS > MEM_CELLS) begin
         for (i = 0; i < SCREEN_CELLS; i++)
            cell_mem[i % MEM_CELLS] = cell_mem[(view_start + i) % MEM_CELLS];
         cursor_pos = step_back(cursor_pos, view_start);
         view_start = 0;
      end
      for (i = 0; i < COLS; i++)
         write_cell(view_start + SCREEN_CELLS + i, blank_word);
      view_start = (view_start + COLS) % MEM_CELLS;
      cursor_pos = (cursor_pos + COLS) % MEM_CELLS;
   endtask

   task automatic line_feed();
      if (row_pos + 1 < ROWS) begin
         row_pos++;
         cursor_pos = (cursor_pos + COLS) % MEM_CELLS;
      end else begin
         scroll_screen();
      end
   endtask

   task automatic carriage_return();
      cursor_pos = step_back(cursor_pos, col_pos);
      col_pos = 0;
   endtask

   task automatic console_char(input logic [7:0] ch, output logic beep);
      beep = 1'b0;
      case (ch)
         tcw_pkg::CHR_NUL, tcw_pkg::CHR_ENQ, tcw_pkg::CHR_HT, tcw_pkg::CHR_VT: ;
         tcw_pkg::CHR_BEL: beep = 1'b1;
         tcw_pkg::CHR_BS: begin
            if (col_pos > 0) begin
               col_pos--;
               cursor_pos = step_back(cursor_pos, 1);
               write_cell(cursor_pos, blank_word);
            end
         end
         tcw_pkg::CHR_LF: begin
            line_feed();
            carriage_return();
         end
         tcw_pkg::CHR_FF: line_feed();
         tcw_pkg::CHR_CR: carriage_return();
         tcw_pkg::CHR_DEL: write_cell(cursor_pos, blank_word);
         default: begin
            // pending wrap moves to the next line first
            if (col_pos >= COLS) begin
               line_feed();
               carriage_return();
            end
            write_cell(cursor_pos, {attr_byte, ch});
            cursor_pos = (cursor_pos + 1) % MEM_CELLS;
            col_pos++;
         end
      endcase
   endtask

   task automatic predict_console(input logic [1:0] mode, input logic [7:0] ch,
                                  input logic last, input logic [12:0] rd,
                                  output console_status_type st);
      logic        beep;
      logic [15:0] data;
      int unsigned i;
      beep = 1'b0;
      data = '0;
      case (mode)
         tcw_pkg::MODE_WRITE: begin
            console_char(ch, beep);
            if (last)
               cursor_reg = cursor_pos;
         end
         tcw_pkg::MODE_READ: data = cell_mem[rd % MEM_CELLS];
         tcw_pkg::MODE_CLEAR: begin
            view_start = 0;
            cursor_pos = 0;
            cursor_reg = 0;
            col_pos    = 0;
            row_pos    = 0;
            for (i = 0; i < MEM_CELLS; i++)
               cell_mem[i] = blank_word;
         end
         default: ;
      endcase
      st.cursor_register = cursor_reg[12:0];
      st.screen_start    = view_start[12:0];
      st.column          = col_pos[6:0];
      st.line            = row_pos[4:0];
      st.beep            = beep;
      st.cell_data       = data;
   endtask

   task automatic report_mismatch(input string msg);
      $display("ERROR: response %0d: %s", rsp_seen, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   // monitor: register writes, accepted requests, accepted responses
   always @(posedge clock) begin : monitor
      console_status_type st;
      if (reset) begin
         view_start = 0;
         cursor_pos = 0;
         cursor_reg = 0;
         col_pos    = 0;
         row_pos    = 0;
         attr_byte  = tcw_pkg::ATTR_RESET;
         blank_word = tcw_pkg::BLANK_RESET;
         expected_status.delete();
         pending_count <= 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == tcw_pkg::CSR_CHAR_ATTRIBUTE)
               attr_byte = csr_write_data[7:0];
            else
               blank_word = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            predict_console(req_mode, req_char_code, req_last_of_write, req_read_cell, st);
            expected_status.push_back(st);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_status.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               st = expected_status.pop_front();
               check_field("cursor_register", rsp_cursor_register, st.cursor_register);
               check_field("screen_start", rsp_screen_start, st.screen_start);
               check_field("column", rsp_column, st.column);
               check_field("line", rsp_line, st.line);
               check_field("beep", rsp_beep, st.beep);
               check_field("cell_data", rsp_cell_data, st.cell_data);
            end
            rsp_seen++;
         end
         pending_count <= expected_status.size();
      end
   end

endmodule

/* bench/text_console_writer_tb.sv */
// ----------------------------------------------------------------------------
// text_console_writer_tb: top-level bench of the text console writer
// Drives a short directed sequence of control bytes, reads and modes,
// then phases of random text lines and noise under several attribute and
// blank settings, with random sender bursts and receiver stalls. Checking
// is done by the checker instance; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_writer_tb;

   localparam int         COLS            = 80;
   localparam int         ROWS            = 25;
   localparam int         MEM_CELLS       = 8192;
   localparam int         CYCLE_LIMIT     = 2_000_000;
   localparam int         ITEMS_PER_PHASE = 375;
   localparam int         END_WAIT        = 40;
   localparam logic [1:0] MODE_UNUSED     = 2'd3;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        csr_write_enable  = 1'b0;
   logic        csr_index         = tcw_pkg::CSR_CHAR_ATTRIBUTE;
   logic [15:0] csr_write_data    = '0;
   logic        req_valid         = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode          = tcw_pkg::MODE_WRITE;
   logic [7:0]  req_char_code     = '0;
   logic        req_last_of_write = 1'b0;
   logic [12:0] req_read_cell     = '0;
   logic        rsp_valid;
   logic        rsp_stall         = 1'b0;
   logic [12:0] rsp_cursor_register;
   logic [12:0] rsp_screen_start;
   logic [6:0]  rsp_column;
   logic [4:0]  rsp_line;
   logic        rsp_beep;
   logic [15:0] rsp_cell_data;

   int   fail_count;
   int   pending_count;
   int   cycle_count = 0;
   int   items_sent  = 0;
   int   burst_left  = 0;
   int   stall_left  = 0;
   logic stall_now   = 1'b0;

   always #2 clock = ~clock;

   text_console_writer #(
      .COLS      (COLS),
      .ROWS      (ROWS),
      .MEM_CELLS (MEM_CELLS)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_char_code       (req_char_code),
      .req_last_of_write   (req_last_of_write),
      .req_read_cell       (req_read_cell),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cursor_register (rsp_cursor_register),
      .rsp_screen_start    (rsp_screen_start),
      .rsp_column          (rsp_column),
      .rsp_line            (rsp_line),
      .rsp_beep            (rsp_beep),
      .rsp_cell_data       (rsp_cell_data)
   );

   text_console_writer_checker #(
      .COLS      (COLS),
      .ROWS      (ROWS),
      .MEM_CELLS (MEM_CELLS)
   ) u_checker (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_char_code       (req_char_code),
      .req_last_of_write   (req_last_of_write),
      .req_read_cell       (req_read_cell),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cursor_register (rsp_cursor_register),
      .rsp_screen_start    (rsp_screen_start),
      .rsp_column          (rsp_column),
      .rsp_line            (rsp_line),
      .rsp_beep            (rsp_beep),
      .rsp_cell_data       (rsp_cell_data),
      .fail_count          (fail_count),
      .pending_count       (pending_count)
   );

   // receiver stall pattern: short random runs, now and then a calm stretch
   always @(negedge clock) begin
      if (stall_left == 0) begin
         if ($urandom_range(0, 19) == 0) begin
            stall_now  = 1'b0;
            stall_left = $urandom_range(100, 300);
         end else begin
            stall_now  = ($urandom_range(0, 2) == 0);
            stall_left = $urandom_range(1, 8);
         end
      end
      stall_left--;
      rsp_stall <= stall_now;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic bit is_control(input logic [7:0] ch);
      case (ch)
         tcw_pkg::CHR_NUL, tcw_pkg::CHR_ENQ, tcw_pkg::CHR_BEL, tcw_pkg::CHR_BS,
         tcw_pkg::CHR_HT, tcw_pkg::CHR_LF, tcw_pkg::CHR_VT, tcw_pkg::CHR_FF,
         tcw_pkg::CHR_CR, tcw_pkg::CHR_DEL: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // mostly plain ASCII, sometimes any byte that prints
   function automatic logic [7:0] printable_byte();
      logic [7:0] ch;
      if ($urandom_range(0, 3) != 0) begin
         ch = 8'($urandom_range(8'h20, 8'h7E));
      end else begin
         do
            ch = 8'($urandom_range(0, 255));
         while (is_control(ch));
      end
      return ch;
   endfunction

   function automatic logic [7:0] control_byte();
      case ($urandom_range(0, 9))
         0: return tcw_pkg::CHR_NUL;
         1: return tcw_pkg::CHR_ENQ;
         2: return tcw_pkg::CHR_BEL;
         3: return tcw_pkg::CHR_HT;
         4: return tcw_pkg::CHR_VT;
         5: return tcw_pkg::CHR_LF;
         6: return tcw_pkg::CHR_FF;
         7: return tcw_pkg::CHR_CR;
         8: return tcw_pkg::CHR_DEL;
         default: return tcw_pkg::CHR_BS;
      endcase
   endfunction

   // one request transaction, then sender burst/gap pacing
   task automatic send_item(input logic [1:0] mode, input logic [7:0] ch,
                            input logic last, input logic [12:0] rd);
      int gap;
      @(negedge clock);
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_char_code     <= ch;
      req_last_of_write <= last;
      req_read_cell     <= rd;
      do
         @(posedge clock);
      while (req_stall);
      items_sent++;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 5);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic send_char(input logic [7:0] ch, input logic last);
      send_item(tcw_pkg::MODE_WRITE, ch, last, 13'($urandom));
   endtask

   task automatic read_back(input logic [12:0] rd);
      send_item(tcw_pkg::MODE_READ, 8'($urandom), 1'($urandom), rd);
   endtask

   // hold the sender until every expected response has arrived
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_config(input logic [7:0] attr, input logic [15:0] blank);
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= tcw_pkg::CSR_CHAR_ATTRIBUTE;
      csr_write_data   <= {8'($urandom), attr};
      @(negedge clock);
      csr_index        <= tcw_pkg::CSR_BLANK_CELL;
      csr_write_data   <= blank;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // a text line with a random terminator; mostly short lines so the
   // screen scrolls often, a few long ones to force wraps
   task automatic send_line();
      int   len;
      int   i;
      int   roll;
      int   term;
      logic last_end;
      roll     = $urandom_range(0, 99);
      term     = $urandom_range(0, 9);
      last_end = ($urandom_range(0, 3) != 0);
      if (roll < 70)
         len = $urandom_range(0, 4);
      else if (roll < 95)
         len = $urandom_range(5, 30);
      else
         len = $urandom_range(75, 90);
      for (i = 0; i < len; i++)
         send_char(printable_byte(), (i == len - 1) && (term == 9) && last_end);
      if (term <= 5) begin
         send_char(tcw_pkg::CHR_LF, last_end);
      end else if (term == 6) begin
         send_char(tcw_pkg::CHR_CR, 1'b0);
         send_char(tcw_pkg::CHR_LF, last_end);
      end else if (term == 7) begin
         send_char(tcw_pkg::CHR_FF, last_end);
      end else if (term == 8) begin
         send_char(tcw_pkg::CHR_CR, last_end);
      end
   endtask

   task automatic run_phase(input int count);
      int target;
      int roll;
      target = items_sent + count;
      while (items_sent < target) begin
         roll = $urandom_range(0, 99);
         if (roll < 70)
            send_line();
         else if (roll < 80)
            send_char(control_byte(), 1'($urandom));
         else if (roll < 88)
            send_char(8'($urandom), 1'($urandom));
         else if (roll < 97)
            read_back(13'($urandom));
         else
            send_item(MODE_UNUSED, 8'($urandom), 1'($urandom), 13'($urandom));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_config(8'h1F, 16'h1F20);

      // directed: clear first so every later read hits a written cell
      send_item(tcw_pkg::MODE_CLEAR, 8'h00, 1'b0, 13'h0000);
      send_char(tcw_pkg::CHR_NUL, 1'b0);
      send_char(tcw_pkg::CHR_ENQ, 1'b0);
      send_char(tcw_pkg::CHR_HT, 1'b0);
      send_char(tcw_pkg::CHR_VT, 1'b1);
      send_char(tcw_pkg::CHR_BEL, 1'b0);
      send_char(tcw_pkg::CHR_BS, 1'b0);     // backspace at column 0
      send_char(8'hFF, 1'b0);
      send_char(8'h01, 1'b0);
      send_char(8'h80, 1'b1);
      send_char(tcw_pkg::CHR_BS, 1'b0);
      send_char(tcw_pkg::CHR_DEL, 1'b0);
      send_char(8'h20, 1'b1);
      send_char(tcw_pkg::CHR_CR, 1'b0);
      send_char(tcw_pkg::CHR_FF, 1'b0);
      send_char(tcw_pkg::CHR_LF, 1'b1);
      read_back(13'h0000);
      read_back(13'h1FFF);
      read_back(13'h0001);
      send_item(MODE_UNUSED, 8'hFF, 1'b1, 13'h1FFF);
      read_back(13'd80);

      // random phases across attribute and blank settings, extremes first
      write_config(8'h00, 16'h0000);
      run_phase(ITEMS_PER_PHASE);
      write_config(8'hFF, 16'hFFFF);
      run_phase(ITEMS_PER_PHASE);
      write_config(8'($urandom), 16'($urandom));
      run_phase(ITEMS_PER_PHASE);
      write_config(tcw_pkg::ATTR_RESET, tcw_pkg::BLANK_RESET);
      run_phase(ITEMS_PER_PHASE);
      write_config(8'($urandom), 16'($urandom));
      send_item(tcw_pkg::MODE_CLEAR, 8'($urandom), 1'($urandom), 13'($urandom));
      run_phase(ITEMS_PER_PHASE);

      drain();
      repeat (END_WAIT) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* text_console_writer.f */
src/tcw_pkg.sv
src/tcw_ctrl.sv
src/tcw_datapath.sv
src/text_console_writer.sv
bench/text_console_writer_checker.sv
bench/text_console_writer_tb.sv
